// ===== rtl/qfp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qfp_pkg
// Shared types and codes of the QUIC frame parser: result item, status
// codes and frame type codes.
// ----------------------------------------------------------------------------
package qfp_pkg;

  localparam int unsigned MaxBufferBytesDef = 65536;

  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusTrunc   = 2'd1;
  localparam logic [1:0] StatusUnknown = 2'd2;

  localparam logic [7:0] FtPadding            = 8'h00;
  localparam logic [7:0] FtPing               = 8'h01;
  localparam logic [7:0] FtAck                = 8'h02;
  localparam logic [7:0] FtAckEcn             = 8'h03;
  localparam logic [7:0] FtResetStream        = 8'h04;
  localparam logic [7:0] FtStopSending        = 8'h05;
  localparam logic [7:0] FtCrypto             = 8'h06;
  localparam logic [7:0] FtNewToken           = 8'h07;
  localparam logic [4:0] FtStreamBase         = 5'b00001;
  localparam logic [7:0] FtMaxData            = 8'h10;
  localparam logic [7:0] FtMaxStreamData      = 8'h11;
  localparam logic [7:0] FtMaxStreamsBidi     = 8'h12;
  localparam logic [7:0] FtMaxStreamsUni      = 8'h13;
  localparam logic [7:0] FtDataBlocked        = 8'h14;
  localparam logic [7:0] FtStreamDataBlocked  = 8'h15;
  localparam logic [7:0] FtStreamsBlockedBidi = 8'h16;
  localparam logic [7:0] FtStreamsBlockedUni  = 8'h17;
  localparam logic [7:0] FtNewConnId          = 8'h18;
  localparam logic [7:0] FtRetireConnId       = 8'h19;
  localparam logic [7:0] FtPathChallenge      = 8'h1a;
  localparam logic [7:0] FtPathResponse       = 8'h1b;
  localparam logic [7:0] FtCloseQuic          = 8'h1c;
  localparam logic [7:0] FtCloseApp           = 8'h1d;
  localparam logic [7:0] FtHandshakeDone      = 8'h1e;

  typedef struct packed {
    logic [1:0]  status;
    logic [61:0] frame_kind;
    logic [61:0] field_first;
    logic [61:0] field_second;
    logic [61:0] ack_range_total;
    logic [61:0] ack_first_range;
    logic [15:0] payload_length;
    logic [15:0] payload_start;
    logic [15:0] frame_bytes;
    logic        stream_fin;
    logic        close_is_app;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/qfp_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qfp_core
// Per-byte frame grammar walk: varint assembly, phase sequencing, length
// checks and result build, one byte per cycle while in_fire_i is high.
// ----------------------------------------------------------------------------
module qfp_core #(
  parameter int unsigned MAX_BUFFER_BYTES = qfp_pkg::MaxBufferBytesDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_fire_i,
  input  wire logic [7:0]      data_byte_i,
  input  wire logic            buffer_end_i,
  output logic                 res_valid_o,
  output qfp_pkg::result_t     res_o
);

  localparam logic [16:0] MaxBytes = 17'(MAX_BUFFER_BYTES);

  typedef enum logic [18:0] {
    PhType       = 19'h00001,
    PhAckLargest = 19'h00002,
    PhAckDelay   = 19'h00004,
    PhAckCount   = 19'h00008,
    PhAckFirst   = 19'h00010,
    PhSkipV      = 19'h00020,
    PhCryptoOff  = 19'h00040,
    PhCryptoLen  = 19'h00080,
    PhPayload    = 19'h00100,
    PhStreamId   = 19'h00200,
    PhStreamOff  = 19'h00400,
    PhStreamLen  = 19'h00800,
    PhToEnd      = 19'h01000,
    PhMaxData    = 19'h02000,
    PhCloseErr   = 19'h04000,
    PhCloseFt    = 19'h08000,
    PhCloseLen   = 19'h10000,
    PhCidLen     = 19'h20000,
    PhTokenLen   = 19'h40000
  } phase_e;

  typedef enum logic [1:0] {
    EvNone    = 2'd0,
    EvDone    = 2'd1,
    EvTrunc   = 2'd2,
    EvUnknown = 2'd3
  } event_e;

  phase_e      phase_q, phase_d;
  logic [61:0] acc_q, acc_d;
  logic [2:0]  vleft_q, vleft_d;
  logic [15:0] pos_q, pos_d;
  logic [61:0] kind_q, kind_d;
  logic [61:0] first_q, first_d;
  logic [61:0] second_q, second_d;
  logic [61:0] rtotal_q, rtotal_d;
  logic [61:0] frange_q, frange_d;
  logic [63:0] vskip_q, vskip_d;
  logic [15:0] bskip_q, bskip_d;
  logic [15:0] plen_q, plen_d;
  logic [15:0] pstart_q, pstart_d;
  logic        drain_q, drain_d;

  event_e      ev;
  logic [15:0] pos_n;
  logic [16:0] room;
  logic [61:0] acc_n;
  logic [2:0]  vleft_n;
  logic        eb_go, eb_report, sk_go, as_go, sao_go;
  logic [61:0] eb_len;
  logic [63:0] sk_n;

  always_comb begin
    phase_d  = phase_q;
    acc_d    = acc_q;
    vleft_d  = vleft_q;
    pos_d    = pos_q;
    kind_d   = kind_q;
    first_d  = first_q;
    second_d = second_q;
    rtotal_d = rtotal_q;
    frange_d = frange_q;
    vskip_d  = vskip_q;
    bskip_d  = bskip_q;
    plen_d   = plen_q;
    pstart_d = pstart_q;
    drain_d  = drain_q;
    ev        = EvNone;
    eb_go     = 1'b0;
    eb_report = 1'b0;
    eb_len    = '0;
    sk_go     = 1'b0;
    sk_n      = '0;
    as_go     = 1'b0;
    sao_go    = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;

    pos_n = (pos_q != 16'hFFFF) ? pos_q + 16'd1 : pos_q;
    room  = ({1'b0, pos_n} >= MaxBytes) ? 17'd0 : MaxBytes - {1'b0, pos_n};

    // varint assembler: first byte gives the length in its top two bits
    if (vleft_q == 3'd0) begin
      acc_n = {56'd0, data_byte_i[5:0]};
      case (data_byte_i[7:6])
        2'd0:    vleft_n = 3'd0;
        2'd1:    vleft_n = 3'd1;
        2'd2:    vleft_n = 3'd3;
        default: vleft_n = 3'd7;
      endcase
    end else begin
      acc_n   = {acc_q[53:0], data_byte_i};
      vleft_n = vleft_q - 3'd1;
    end

    if (in_fire_i) begin
      if (drain_q) begin
        if (buffer_end_i) begin
          drain_d = 1'b0;
        end
      end else begin
        pos_d = pos_n;
        case (phase_q)
          PhPayload: begin
            if (bskip_q != 16'd0) begin
              bskip_d = bskip_q - 16'd1;
            end
            if (bskip_d == 16'd0) begin
              ev = EvDone;
            end
          end
          PhToEnd: begin
            if (buffer_end_i) begin
              plen_d = (pos_n >= pstart_q) ? pos_n - pstart_q : 16'd0;
              ev = EvDone;
            end
          end
          PhCidLen: begin
            eb_go  = 1'b1;
            eb_len = {54'd0, data_byte_i} + 62'd16;
          end
          default: begin
            acc_d   = acc_n;
            vleft_d = vleft_n;
            if (vleft_n == 3'd0) begin
              case (phase_q)
                PhType: begin
                  kind_d = acc_n;
                  if (acc_n[61:8] != '0) begin
                    ev = EvUnknown;
                  end else if (acc_n[7:3] == qfp_pkg::FtStreamBase) begin
                    phase_d = PhStreamId;
                  end else begin
                    case (acc_n[7:0])
                      qfp_pkg::FtPadding, qfp_pkg::FtPing,
                      qfp_pkg::FtHandshakeDone: ev = EvDone;
                      qfp_pkg::FtAck, qfp_pkg::FtAckEcn: phase_d = PhAckLargest;
                      qfp_pkg::FtResetStream: begin
                        sk_go = 1'b1;
                        sk_n  = 64'd3;
                      end
                      qfp_pkg::FtStopSending, qfp_pkg::FtMaxStreamData,
                      qfp_pkg::FtStreamDataBlocked, qfp_pkg::FtNewConnId: begin
                        sk_go = 1'b1;
                        sk_n  = 64'd2;
                      end
                      qfp_pkg::FtMaxStreamsBidi, qfp_pkg::FtMaxStreamsUni,
                      qfp_pkg::FtDataBlocked, qfp_pkg::FtStreamsBlockedBidi,
                      qfp_pkg::FtStreamsBlockedUni, qfp_pkg::FtRetireConnId: begin
                        sk_go = 1'b1;
                        sk_n  = 64'd1;
                      end
                      qfp_pkg::FtCrypto:   phase_d = PhCryptoOff;
                      qfp_pkg::FtNewToken: phase_d = PhTokenLen;
                      qfp_pkg::FtMaxData:  phase_d = PhMaxData;
                      qfp_pkg::FtPathChallenge, qfp_pkg::FtPathResponse: begin
                        eb_go  = 1'b1;
                        eb_len = 62'd8;
                      end
                      qfp_pkg::FtCloseQuic, qfp_pkg::FtCloseApp: phase_d = PhCloseErr;
                      default: ev = EvUnknown;
                    endcase
                  end
                end
                PhAckLargest: begin
                  first_d = acc_n;
                  phase_d = PhAckDelay;
                end
                PhAckDelay: begin
                  second_d = acc_n;
                  phase_d  = PhAckCount;
                end
                PhAckCount: begin
                  rtotal_d = acc_n;
                  phase_d  = PhAckFirst;
                end
                PhAckFirst: begin
                  frange_d = acc_n;
                  sk_go    = 1'b1;
                  sk_n     = {1'b0, rtotal_q, 1'b0} +
                             ((kind_q == {54'd0, qfp_pkg::FtAckEcn}) ? 64'd3 : 64'd0);
                end
                PhSkipV: begin
                  vskip_d = vskip_q - 64'd1;
                  if (vskip_d == 64'd0) begin
                    as_go = 1'b1;
                  end
                end
                PhCryptoOff: begin
                  first_d = acc_n;
                  phase_d = PhCryptoLen;
                end
                PhStreamId: begin
                  first_d = acc_n;
                  if (kind_q[2]) begin
                    phase_d = PhStreamOff;
                  end else begin
                    sao_go = 1'b1;
                  end
                end
                PhStreamOff: begin
                  second_d = acc_n;
                  sao_go   = 1'b1;
                end
                PhMaxData: begin
                  first_d = acc_n;
                  ev      = EvDone;
                end
                PhCloseErr: begin
                  first_d = acc_n;
                  phase_d = (kind_q == {54'd0, qfp_pkg::FtCloseQuic}) ? PhCloseFt
                                                                      : PhCloseLen;
                end
                PhCloseFt: begin
                  second_d = acc_n;
                  phase_d  = PhCloseLen;
                end
                PhCryptoLen, PhStreamLen, PhCloseLen: begin
                  eb_go     = 1'b1;
                  eb_report = 1'b1;
                  eb_len    = acc_n;
                end
                PhTokenLen: begin
                  eb_go  = 1'b1;
                  eb_len = acc_n;
                end
                default: ;
              endcase
            end
          end
        endcase

        // stream: length field follows, or data runs to the buffer end
        if (sao_go) begin
          if (kind_q[1]) begin
            phase_d = PhStreamLen;
          end else begin
            pstart_d = pos_n;
            plen_d   = 16'd0;
            if (buffer_end_i) begin
              ev = EvDone;
            end else begin
              phase_d = PhToEnd;
            end
          end
        end

        if (sk_go) begin
          if (sk_n == 64'd0) begin
            as_go = 1'b1;
          end else begin
            vskip_d = sk_n;
            phase_d = PhSkipV;
          end
        end

        if (as_go) begin
          if (kind_d == {54'd0, qfp_pkg::FtNewConnId}) begin
            phase_d = PhCidLen;
          end else begin
            ev = EvDone;
          end
        end

        // check the declared length against room left in the buffer
        if (eb_go) begin
          if ((eb_len[61:17] != '0) || (eb_len[16:0] > room)) begin
            ev = EvTrunc;
          end else begin
            if (eb_report) begin
              plen_d   = eb_len[15:0];
              pstart_d = pos_n;
            end
            if (eb_len == '0) begin
              ev = EvDone;
            end else begin
              bskip_d = eb_len[15:0];
              phase_d = PhPayload;
            end
          end
        end

        if ((ev == EvNone) && buffer_end_i) begin
          ev = EvTrunc;
        end

        if (ev != EvNone) begin
          res_valid_o       = 1'b1;
          res_o.frame_kind  = kind_d;
          res_o.frame_bytes = pos_n;
          case (ev)
            EvDone: begin
              res_o.status          = qfp_pkg::StatusOk;
              res_o.field_first     = first_d;
              res_o.field_second    = second_d;
              res_o.ack_range_total = rtotal_d;
              res_o.ack_first_range = frange_d;
              res_o.payload_length  = plen_d;
              res_o.payload_start   = pstart_d;
              res_o.stream_fin      = (kind_d[61:3] == 59'd1) ? kind_d[0] : 1'b0;
              res_o.close_is_app    = (kind_d == {54'd0, qfp_pkg::FtCloseApp});
            end
            EvTrunc:  res_o.status = qfp_pkg::StatusTrunc;
            default:  res_o.status = qfp_pkg::StatusUnknown;
          endcase
          drain_d  = (ev != EvDone) && !buffer_end_i;
          // start a fresh frame
          phase_d  = PhType;
          acc_d    = '0;
          vleft_d  = '0;
          pos_d    = '0;
          kind_d   = '0;
          first_d  = '0;
          second_d = '0;
          rtotal_d = '0;
          frange_d = '0;
          vskip_d  = '0;
          bskip_d  = '0;
          plen_d   = '0;
          pstart_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhType;
      acc_q    <= '0;
      vleft_q  <= '0;
      pos_q    <= '0;
      kind_q   <= '0;
      first_q  <= '0;
      second_q <= '0;
      rtotal_q <= '0;
      frange_q <= '0;
      vskip_q  <= '0;
      bskip_q  <= '0;
      plen_q   <= '0;
      pstart_q <= '0;
      drain_q  <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      acc_q    <= acc_d;
      vleft_q  <= vleft_d;
      pos_q    <= pos_d;
      kind_q   <= kind_d;
      first_q  <= first_d;
      second_q <= second_d;
      rtotal_q <= rtotal_d;
      frange_q <= frange_d;
      vskip_q  <= vskip_d;
      bskip_q  <= bskip_d;
      plen_q   <= plen_d;
      pstart_q <= pstart_d;
      drain_q  <= drain_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/qfp_outq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qfp_outq
// Result register with one skid stage, so the parser keeps taking bytes
// while a result waits downstream.
// ----------------------------------------------------------------------------
module qfp_outq (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              res_valid_i,
  input  wire qfp_pkg::result_t  res_i,
  input  wire logic              out_stall_i,
  output logic                   out_valid_o,
  output qfp_pkg::result_t       out_res_o,
  output logic                   in_stall_o
);

  logic             ov_q, sv_q;
  qfp_pkg::result_t od_q, sd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      sv_q <= 1'b0;
    end else if (!ov_q || !out_stall_i) begin
      // output slot frees: take the skid item first
      if (sv_q) begin
        ov_q <= 1'b1;
        sv_q <= res_valid_i;
      end else begin
        ov_q <= res_valid_i;
      end
    end else if (res_valid_i) begin
      sv_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!ov_q || !out_stall_i) begin
      if (sv_q) begin
        od_q <= sd_q;
        sd_q <= res_i;
      end else begin
        od_q <= res_i;
      end
    end else if (res_valid_i) begin
      sd_q <= res_i;
    end
  end

  assign out_valid_o = ov_q;
  assign out_res_o   = od_q;
  assign in_stall_o  = sv_q;

endmodule
`default_nettype wire

// ===== rtl/quic_frame_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// quic_frame_parser
// QUIC frame parser: one payload byte per item, one descriptor per frame.
// ----------------------------------------------------------------------------
// Takes one payload byte every cycle while input stall is low and walks the
// frame grammar in a single registered pass per byte; a frame descriptor, or
// an error for a truncated frame or unknown type, raised by the byte that ends
// it, is registered in the result register, or in the skid stage behind it
// while the output is stalled; that stage lets one more result collect, and
// input stall rises only when it is full. After an error, bytes are dropped
// up to the byte flagged as buffer end.
module quic_frame_parser #(
  parameter int unsigned MAX_BUFFER_BYTES = qfp_pkg::MaxBufferBytesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        buffer_end_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       status_o,
  output logic [61:0]      frame_kind_o,
  output logic [61:0]      field_first_o,
  output logic [61:0]      field_second_o,
  output logic [61:0]      ack_range_total_o,
  output logic [61:0]      ack_first_range_o,
  output logic [15:0]      payload_length_o,
  output logic [15:0]      payload_start_o,
  output logic [15:0]      frame_bytes_o,
  output logic             stream_fin_o,
  output logic             close_is_app_o
);

  logic             in_fire;
  logic             res_valid;
  qfp_pkg::result_t res;
  qfp_pkg::result_t out_res;

  assign in_fire = in_valid_i && !in_stall_o;

  qfp_core #(
    .MAX_BUFFER_BYTES(MAX_BUFFER_BYTES)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_fire_i   (in_fire),
    .data_byte_i (data_byte_i),
    .buffer_end_i(buffer_end_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  qfp_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_valid_i(res_valid),
    .res_i      (res),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .out_res_o  (out_res),
    .in_stall_o (in_stall_o)
  );

  assign status_o          = out_res.status;
  assign frame_kind_o      = out_res.frame_kind;
  assign field_first_o     = out_res.field_first;
  assign field_second_o    = out_res.field_second;
  assign ack_range_total_o = out_res.ack_range_total;
  assign ack_first_range_o = out_res.ack_first_range;
  assign payload_length_o  = out_res.payload_length;
  assign payload_start_o   = out_res.payload_start;
  assign frame_bytes_o     = out_res.frame_bytes;
  assign stream_fin_o      = out_res.stream_fin;
  assign close_is_app_o    = out_res.close_is_app;

endmodule
`default_nettype wire
